>>> rtl/core/tlpw_pkg.sv
// Package for the two-level page walk block.
// Holds sizes, register, request kind and status codes, entry bits, the result word type and the bounds check.
// No dependencies.
package tlpw_pkg;

    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) << 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LIMIT_W    = 19;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd262144;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd3;

    localparam logic KIND_WRITE     = 1'b0;
    localparam logic KIND_TRANSLATE = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BEYOND    = 3'd1;
    localparam logic [2:0] ST_PAE       = 3'd2;
    localparam logic [2:0] ST_DIR_OUT   = 3'd3;
    localparam logic [2:0] ST_DIR_ABS   = 3'd4;
    localparam logic [2:0] ST_TBL_OUT   = 3'd5;
    localparam logic [2:0] ST_TBL_ABS   = 3'd6;

    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_LARGE_BIT   = 7;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] physical_address;
        logic        large_page;
        logic [9:0]  dir_index;
        logic [31:0] dir_entry;
        logic [9:0]  table_index;
        logic [31:0] table_entry;
    } result_t;

    function automatic logic in_bounds(input logic [31:0] pa, input logic [LIMIT_W-1:0] lim);
        logic [32:0] last;
        last = {1'b0, pa} + 33'd4;
        return (last <= 33'(lim)) && (last <= MEM_BYTES);
    endfunction

endpackage

>>> rtl/core/tlpw_chan_if.sv
// Channel interfaces of the two-level page walk block: request, result, config write.
// Depends on tlpw_pkg.
interface tlpw_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] word_address;
    logic [31:0] write_data;
    logic [63:0] virtual_address;

    modport source (output valid, kind, word_address, write_data, virtual_address,
                    input ready);
    modport sink   (input valid, kind, word_address, write_data, virtual_address,
                    output ready);
endinterface

interface tlpw_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] physical_address;
    logic        large_page;
    logic [9:0]  dir_index;
    logic [31:0] dir_entry;
    logic [9:0]  table_index;
    logic [31:0] table_entry;

    modport source (output valid, status, physical_address, large_page, dir_index,
                    dir_entry, table_index, table_entry, input ready);
    modport sink   (input valid, status, physical_address, large_page, dir_index,
                    dir_entry, table_index, table_entry, output ready);
endinterface

interface tlpw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tlpw_pkg::CFG_IDX_W-1:0]  index;
    logic [tlpw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/two_level_page_walk_top.sv
// Top level of the two-level page walk block: config registers, walk sequencer, result register.
// Depends on tlpw_pkg, tlpw_chan_if and tlpw_ram.
// Write word: taken while idle, no result. Translate: the result word is registered as the walk
// finishes, from S_IDLE at accept with paging off, refused or directory outside, from S_DIR for a
// directory-level finish, from S_TBL after a table read. Input is held while a walk is in S_DIR or
// S_TBL; a held result word stalls the input once the next translate finishes. Reset clears config
// registers to defaults and the sequencer; memory stays undefined until written.
module two_level_page_walk_top (
    input  logic       clk,
    input  logic       rst_n,
    tlpw_req_if.sink   req,
    tlpw_rsp_if.source rsp,
    tlpw_cfg_if.sink   cfg
);

    import tlpw_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIR, S_TBL, S_FIN} state_t;

    state_t              state_reg, state_next;
    logic                paging_reg;
    logic                pae_reg;
    logic [31:0]         dir_base_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [21:0]         va_reg, va_next;
    result_t             work_reg, res;
    result_t             out_reg;
    logic                out_valid_reg;
    logic                fin;
    logic                slot_free;
    logic                ram_en, ram_we;
    logic [MEM_AW-1:0]   ram_addr;
    logic [31:0]         ram_rdata;
    logic [31:0]         dir_pa, tbl_pa;

    tlpw_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req.write_data),
        .rdata (ram_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;

    assign dir_pa = {dir_base_reg[31:12], req.virtual_address[31:22], 2'b00};
    assign tbl_pa = {ram_rdata[31:12], work_reg.table_index, 2'b00};

    always_comb
    begin
        state_next = state_reg;
        res        = work_reg;
        va_next    = va_reg;
        fin        = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.kind == KIND_WRITE)
                    begin
                        ram_en   = (32'(req.word_address) < MEM_WORDS);
                        ram_we   = 1'b1;
                        ram_addr = MEM_AW'(req.word_address);
                    end
                    else
                    begin
                        res     = '0;
                        va_next = req.virtual_address[21:0];
                        if (!paging_reg)
                        begin
                            fin = 1'b1;
                            if (req.virtual_address >= 64'(limit_reg))
                            begin
                                res.status = ST_BEYOND;
                            end
                            else
                            begin
                                res.physical_address = req.virtual_address[31:0];
                            end
                        end
                        else if (pae_reg)
                        begin
                            fin        = 1'b1;
                            res.status = ST_PAE;
                        end
                        else
                        begin
                            res.dir_index   = req.virtual_address[31:22];
                            res.table_index = req.virtual_address[21:12];
                            if (in_bounds(dir_pa, limit_reg))
                            begin
                                ram_en     = 1'b1;
                                ram_addr   = dir_pa[MEM_AW+1:2];
                                state_next = S_DIR;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                res.status = ST_DIR_OUT;
                            end
                        end
                    end
                end
            end
            S_DIR:
            begin
                res.dir_entry = ram_rdata;
                if (!ram_rdata[ENT_PRESENT_BIT])
                begin
                    fin        = 1'b1;
                    res.status = ST_DIR_ABS;
                end
                else if (ram_rdata[ENT_LARGE_BIT])
                begin
                    fin                  = 1'b1;
                    res.large_page       = 1'b1;
                    res.physical_address = {ram_rdata[31:22], va_reg[21:0]};
                end
                else if (in_bounds(tbl_pa, limit_reg))
                begin
                    ram_en     = 1'b1;
                    ram_addr   = tbl_pa[MEM_AW+1:2];
                    state_next = S_TBL;
                end
                else
                begin
                    fin        = 1'b1;
                    res.status = ST_TBL_OUT;
                end
            end
            S_TBL:
            begin
                fin             = 1'b1;
                res.table_entry = ram_rdata;
                if (!ram_rdata[ENT_PRESENT_BIT])
                begin
                    res.status = ST_TBL_ABS;
                end
                else
                begin
                    res.physical_address = {ram_rdata[31:12], va_reg[11:0]};
                end
            end
            S_FIN:
            begin
                fin = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = slot_free ? S_IDLE : S_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            paging_reg    <= 1'b0;
            pae_reg       <= 1'b0;
            dir_base_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            va_reg        <= '0;
            work_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            va_reg    <= va_next;
            work_reg  <= res;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_PAGING:   paging_reg   <= cfg.data[0];
                    CFG_PAE:      pae_reg      <= cfg.data[0];
                    CFG_DIR_BASE: dir_base_reg <= cfg.data[31:0];
                    CFG_LIMIT:    limit_reg    <= cfg.data[LIMIT_W-1:0];
                    default:      ;
                endcase
            end
            if (fin && slot_free)
            begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_reg.status;
    assign rsp.physical_address = out_reg.physical_address;
    assign rsp.large_page       = out_reg.large_page;
    assign rsp.dir_index        = out_reg.dir_index;
    assign rsp.dir_entry        = out_reg.dir_entry;
    assign rsp.table_index      = out_reg.table_index;
    assign rsp.table_entry      = out_reg.table_entry;

endmodule

>>> rtl/core/tlpw_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tlpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
